>>> hdl/gbrc_pkg.sv
// shared constants, types and weight table builder for the gaussian blur core
package gbrc_pkg;

    localparam int RADIUS_DEF           = 8;
    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int MAX_HEIGHT_DEF       = 1024;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int CFG_W   = 11;
    localparam int PIXEL_W = 32;

    // weight table layout: (RADIUS+1) x (RADIUS+1) words at the largest sizes
    localparam int LUT_N = 9;
    localparam int LUT_W = 21;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } gbrc_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

    // restoring shift-subtract quotient, used only while building the weight table
    function automatic longint unsigned cdiv(input longint unsigned n,
                                             input longint unsigned d);
        logic [64:0]     rem;
        longint unsigned q;
        int k;
        rem = '0;
        q   = 0;
        for (k = 63; k >= 0; k--) begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // q0.frac weight for each pair of absolute offsets, packed row by row
    function automatic logic [LUT_N*LUT_N*LUT_W-1:0] gauss_lut(input int radius,
                                                             input int frac);
        longint unsigned g [LUT_N];
        longint unsigned h [LUT_N];
        longint unsigned total;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned num;
        longint unsigned den;
        longint unsigned step;
        longint unsigned p;
        logic [LUT_N*LUT_N*LUT_W-1:0] r;
        int i;
        int n;
        int a;
        int b;
        r     = '0;
        total = 0;
        for (i = 0; i < LUT_N; i++) begin
            g[i] = 0;
            h[i] = 0;
        end
        for (i = 0; i < LUT_N; i++) begin
            if (i <= radius) begin
                num  = longint'(2 * i * i);
                den  = longint'(radius * radius);
                term = 64'd1 << 30;
                sum  = term;
                for (n = 1; n < 64; n++) begin
                    if (term != 0) begin
                        step = den * longint'(n);
                        term = cdiv(term * num, step);
                        sum  = sum + term;
                    end
                end
                g[i]  = cdiv(64'd1 << 60, sum);
                total = total + ((i == 0) ? g[i] : 2 * g[i]);
            end
        end
        for (i = 0; i < LUT_N; i++) begin
            if (i <= radius) begin
                h[i] = cdiv(g[i] << 30, total);
            end
        end
        for (a = 0; a < LUT_N; a++) begin
            for (b = 0; b < LUT_N; b++) begin
                if (a <= radius && b <= radius) begin
                    p = h[a] * h[b];
                    p = (p + (64'd1 << (59 - frac))) >> (60 - frac);
                    r[(a * LUT_N + b) * LUT_W +: LUT_W] = p[LUT_W-1:0];
                end
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/gbrc_mac.sv
// four-channel multiply-accumulate with truncation and saturation
module gbrc_mac #(
    parameter int WEIGHT_FRAC_BITS = gbrc_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gbrc_pkg::mac_ctl_t            ctl,
    input  logic [gbrc_pkg::PIXEL_W-1:0]  pix,
    input  logic [WEIGHT_FRAC_BITS:0]     wt,
    output logic                          busy,
    output logic [gbrc_pkg::PIXEL_W-1:0]  sat
);
    import gbrc_pkg::*;

    localparam int PW = WEIGHT_FRAC_BITS + 9;
    localparam int SW = WEIGHT_FRAC_BITS + 10;

    logic [PW-1:0] prod_reg [4];
    logic          mul_v_reg;
    logic [SW-1:0] acc_reg  [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else begin
            mul_v_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            if (ctl.valid) begin
                prod_reg[c] <= PW'(wt * pix[8*c +: 8]);
            end
            if (ctl.clear) begin
                acc_reg[c] <= '0;
            end else if (mul_v_reg) begin
                acc_reg[c] <= acc_reg[c] + SW'(prod_reg[c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (acc_reg[c][SW-1:WEIGHT_FRAC_BITS] > 10'd255) begin
                sat[8*c +: 8] = 8'hff;
            end else begin
                sat[8*c +: 8] = acc_reg[c][WEIGHT_FRAC_BITS +: 8];
            end
        end
    end

    assign busy = mul_v_reg;

endmodule

>>> hdl/gaussian_blur_rgba_clamp_core.sv
// top level of the streaming rgba gaussian blur with edge clamping
// a pixel or drain transfer that yields no result leaves the core idle and ready
// a transfer that yields a result occupies the core for a walk over all (2*RADIUS+1)^2
//   taps, one line store read per tap, and s_ready is low
// throughput is set by the single read port of the line store: one tap a cycle
// reset clears all control state; the line store is not cleared and is only
//   read where the current frame already wrote it
module gaussian_blur_rgba_clamp_core #(
    parameter int RADIUS           = gbrc_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH        = gbrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = gbrc_pkg::MAX_HEIGHT_DEF,
    parameter int WEIGHT_FRAC_BITS = gbrc_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_index,
    input  logic [gbrc_pkg::CFG_W-1:0] cfg_wr_data,
    // input pixels and drain ticks
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_in_red,
    input  logic [7:0]                s_in_green,
    input  logic [7:0]                s_in_blue,
    input  logic [7:0]                s_in_alpha,
    // blurred pixels
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_red,
    output logic [7:0]                m_out_green,
    output logic [7:0]                m_out_blue,
    output logic [7:0]                m_out_alpha,
    output logic                      m_frame_last
);
    import gbrc_pkg::*;

    localparam int TAPS  = 2 * RADIUS + 1;
    localparam int DEPTH = TAPS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int TW    = $clog2(TAPS);
    localparam int XW    = CW + 6;
    localparam int YW    = RW + 6;

    localparam logic [LUT_N*LUT_N*LUT_W-1:0] WLUT = gauss_lut(RADIUS, WEIGHT_FRAC_BITS);

    // configuration registers
    logic [CFG_W-1:0] image_width_reg, image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= CFG_W'(1024);
            image_height_reg <= CFG_W'(1024);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // frame size as the next frame will latch it
    logic [WW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;

    always_comb begin
        if (image_width_reg == '0) begin
            cfg_w = WW'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            cfg_w = WW'(MAX_WIDTH);
        end else begin
            cfg_w = WW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            cfg_h = HW'(1);
        end else if (32'(image_height_reg) > 32'(MAX_HEIGHT)) begin
            cfg_h = HW'(MAX_HEIGHT);
        end else begin
            cfg_h = HW'(image_height_reg);
        end
    end

    // control and frame state
    gbrc_state_t state_reg, state_next;
    logic          frame_open_reg, frame_open_next;
    logic          input_done_reg, input_done_next;
    logic [WW-1:0] fw_reg, fw_next;
    logic [HW-1:0] fh_reg, fh_next;
    logic [AW-1:0] rw_reg, rw_next;          // radius * frame width
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [MW-1:0] m_reg, m_next;            // raster index of the next pixel
    logic [AW-1:0] waddr_reg, waddr_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [AW-1:0] out_rb_reg, out_rb_next;  // line store base of the output row

    // per-output tap walk
    logic [CW-1:0]        ox_reg, ox_next;
    logic                 last_reg, last_next;
    logic [TW-1:0]        kx_reg, kx_next, ky_reg, ky_next;
    logic signed [XW-1:0] rx_reg, rx_next;
    logic signed [YW-1:0] ry_reg, ry_next;
    logic [AW-1:0]        rb_reg, rb_next;   // line store base of the tap row

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg;
    logic       m_last_reg;
    logic       load_out;

    // line store
    logic [PIXEL_W-1:0] line_mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;
    logic               issue;
    logic [AW-1:0]      raddr;
    logic [PIXEL_W-1:0] rdata_reg;
    logic               rd_v_reg;
    logic [WEIGHT_FRAC_BITS:0] wt_reg;

    // mac interface
    mac_ctl_t           mac_ctl;
    logic               mac_busy;
    logic [PIXEL_W-1:0] mac_sat;
    logic               start;

    logic               s_xfer;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // tap address: clamp the column, add the row base, wrap around the ring; look up the tap weight
    logic [CW-1:0] nx;
    logic [AW:0]   addr_sum;
    logic [TW-1:0] wa, wb;
    logic [LUT_W-1:0] lut_word;

    always_comb begin
        if (rx_reg < 0) begin
            nx = '0;
        end else if (rx_reg >= signed'(XW'(fw_reg))) begin
            nx = CW'(fw_reg - WW'(1));
        end else begin
            nx = rx_reg[CW-1:0];
        end
        addr_sum = {1'b0, rb_reg} + (AW+1)'(nx);
        if (addr_sum >= (AW+1)'(DEPTH)) begin
            raddr = AW'(addr_sum - (AW+1)'(DEPTH));
        end else begin
            raddr = addr_sum[AW-1:0];
        end
        wa       = (ky_reg >= TW'(RADIUS)) ? ky_reg - TW'(RADIUS) : TW'(RADIUS) - ky_reg;
        wb       = (kx_reg >= TW'(RADIUS)) ? kx_reg - TW'(RADIUS) : TW'(RADIUS) - kx_reg;
        lut_word = WLUT[(int'(wa) * LUT_N + int'(wb)) * LUT_W +: LUT_W];
    end

    assign issue = (state_reg == ST_RUN);

    // next state of frame tracking, tap walk and output register
    logic [WW-1:0] w_e;
    logic [HW-1:0] h_e;
    logic [CW-1:0] col_c;
    logic [RW-1:0] row_c;
    logic [MW-1:0] m_c;
    logic [AW-1:0] wa_c;
    logic [AW:0]   rb_inc, orb_inc;
    logic signed [YW-1:0] ry_inc;

    always_comb begin
        state_next      = state_reg;
        frame_open_next = frame_open_reg;
        input_done_next = input_done_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        rw_next         = rw_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        m_next          = m_reg;
        waddr_next      = waddr_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_rb_next     = out_rb_reg;
        ox_next         = ox_reg;
        last_next       = last_reg;
        kx_next         = kx_reg;
        ky_next         = ky_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        rb_next         = rb_reg;
        m_valid_next    = m_valid_reg;
        load_out        = 1'b0;
        start           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = waddr_reg;
        mem_wdata       = {s_in_alpha, s_in_blue, s_in_green, s_in_red};

        w_e   = frame_open_reg ? fw_reg : cfg_w;
        h_e   = frame_open_reg ? fh_reg : cfg_h;
        col_c = frame_open_reg ? in_col_reg : '0;
        row_c = frame_open_reg ? in_row_reg : '0;
        m_c   = frame_open_reg ? m_reg : '0;
        wa_c  = frame_open_reg ? waddr_reg : '0;

        rb_inc  = {1'b0, rb_reg} + (AW+1)'(fw_reg);
        orb_inc = {1'b0, out_rb_reg} + (AW+1)'(fw_reg);
        ry_inc  = ry_reg + signed'(YW'(1));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_kind == KIND_DRAIN) begin
                        start = input_done_reg;
                    end else if (!input_done_reg) begin
                        // pixel transfer: store it and step the input raster
                        frame_open_next = 1'b1;
                        fw_next         = w_e;
                        fh_next         = h_e;
                        rw_next         = AW'(RADIUS * 32'(w_e));
                        mem_we          = 1'b1;
                        mem_waddr       = wa_c;
                        m_next          = m_c + MW'(1);
                        waddr_next      = (32'(wa_c) == DEPTH - 1) ? '0 : wa_c + AW'(1);
                        if (32'(col_c) + 1 >= 32'(w_e)) begin
                            in_col_next = '0;
                            if (32'(row_c) + 1 >= 32'(h_e)) begin
                                in_row_next     = '0;
                                input_done_next = 1'b1;
                            end else begin
                                in_row_next = row_c + RW'(1);
                            end
                        end else begin
                            in_col_next = col_c + CW'(1);
                        end
                        start = frame_open_reg &&
                                (32'(m_c) >= 32'(rw_reg) + 32'(RADIUS));
                    end
                end
                if (start) begin
                    // set up the tap walk for the pending output pixel
                    state_next = ST_RUN;
                    ox_next    = out_col_reg;
                    last_next  = (32'(out_row_reg) == 32'(fh_reg) - 1) &&
                                 (32'(out_col_reg) == 32'(fw_reg) - 1);
                    kx_next    = '0;
                    ky_next    = '0;
                    rx_next    = signed'(XW'(out_col_reg)) - signed'(XW'(RADIUS));
                    ry_next    = signed'(YW'(out_row_reg)) - signed'(YW'(RADIUS));
                    if (32'(out_row_reg) >= RADIUS) begin
                        if (out_rb_reg >= rw_reg) begin
                            rb_next = out_rb_reg - rw_reg;
                        end else begin
                            rb_next = AW'((AW+1)'(out_rb_reg) + (AW+1)'(DEPTH)
                                          - (AW+1)'(rw_reg));
                        end
                    end else begin
                        rb_next = '0;
                    end
                    // step the output raster
                    if (32'(out_col_reg) + 1 >= 32'(fw_reg)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + RW'(1);
                        out_rb_next  = (orb_inc >= (AW+1)'(DEPTH)) ?
                                       AW'(orb_inc - (AW+1)'(DEPTH)) : orb_inc[AW-1:0];
                    end else begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                    if (last_next) begin
                        frame_open_next = 1'b0;
                        input_done_next = 1'b0;
                        in_col_next     = '0;
                        in_row_next     = '0;
                        m_next          = '0;
                        waddr_next      = '0;
                        out_col_next    = '0;
                        out_row_next    = '0;
                        out_rb_next     = '0;
                    end
                end
            end
            ST_RUN: begin
                // one tap a cycle, column inner, row outer
                if (kx_reg == TW'(2 * RADIUS)) begin
                    kx_next = '0;
                    rx_next = signed'(XW'(ox_reg)) - signed'(XW'(RADIUS));
                    if (ky_reg == TW'(2 * RADIUS)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        ky_next = ky_reg + TW'(1);
                        ry_next = ry_inc;
                        // the tap row moves only inside the frame
                        if (ry_inc > 0 && ry_inc <= signed'(YW'(fh_reg)) - signed'(YW'(1))) begin
                            rb_next = (rb_inc >= (AW+1)'(DEPTH)) ?
                                      AW'(rb_inc - (AW+1)'(DEPTH)) : rb_inc[AW-1:0];
                        end
                    end
                end else begin
                    kx_next = kx_reg + TW'(1);
                    rx_next = rx_reg + signed'(XW'(1));
                end
            end
            ST_FLUSH: begin
                // wait for the last products, then hand over to the output register
                if (!rd_v_reg && !mac_busy && (!m_valid_reg || m_ready)) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frame_open_reg <= 1'b0;
            input_done_reg <= 1'b0;
            fw_reg         <= WW'(1);
            fh_reg         <= HW'(1);
            rw_reg         <= AW'(RADIUS);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            m_reg          <= '0;
            waddr_reg      <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_rb_reg     <= '0;
            kx_reg         <= '0;
            ky_reg         <= '0;
            m_valid_reg    <= 1'b0;
            rd_v_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            frame_open_reg <= frame_open_next;
            input_done_reg <= input_done_next;
            fw_reg         <= fw_next;
            fh_reg         <= fh_next;
            rw_reg         <= rw_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            m_reg          <= m_next;
            waddr_reg      <= waddr_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            out_rb_reg     <= out_rb_next;
            kx_reg         <= kx_next;
            ky_reg         <= ky_next;
            m_valid_reg    <= m_valid_next;
            rd_v_reg       <= issue;
        end
    end

    // payload registers of the tap walk and the output
    always_ff @(posedge aclk) begin
        ox_reg   <= ox_next;
        last_reg <= last_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rb_reg   <= rb_next;
        if (load_out) begin
            m_data_reg <= mac_sat;
            m_last_reg <= last_reg;
        end
    end

    // line store: one write port for pixels, one registered read port for taps
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= line_mem[raddr];
            wt_reg    <= lut_word[WEIGHT_FRAC_BITS:0];
        end
    end

    assign mac_ctl.clear = start;
    assign mac_ctl.valid = rd_v_reg;

    gbrc_mac #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .pix     (rdata_reg),
        .wt      (wt_reg),
        .busy    (mac_busy),
        .sat     (mac_sat)
    );

    assign m_valid      = m_valid_reg;
    assign m_out_red    = m_data_reg[7:0];
    assign m_out_green  = m_data_reg[15:8];
    assign m_out_blue   = m_data_reg[23:16];
    assign m_out_alpha  = m_data_reg[31:24];
    assign m_frame_last = m_last_reg;

endmodule

>>> hdl/gbrc_checker.sv
// port-level checks for the gaussian blur core and their bind
module gbrc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic       m_frame_last
);

    // coming out of reset the core is idle with nothing to deliver
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("core not idle after reset");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_red) && $stable(m_frame_last)))
        else $error("stalled result changed");

    // no result can appear in the cycle after an input transfer
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

    // a finished result returns the core to accepting input
    a_ready_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("input not ready when result appeared");

endmodule

bind gaussian_blur_rgba_clamp_core gbrc_checker u_gbrc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_red    (m_out_red),
    .m_frame_last (m_frame_last)
);

>>> dv/tb_gaussian_blur_rgba_clamp_core.sv
// self-checking testbench for the streaming rgba gaussian blur core
`timescale 1ns / 100ps

module tb_gaussian_blur_rgba_clamp_core;
    import gbrc_pkg::*;

    localparam int RAD       = RADIUS_DEF;
    localparam int TAPS      = 2 * RAD + 1;
    localparam int FRAC      = WEIGHT_FRAC_BITS_DEF;
    localparam int DEPTH     = TAPS * MAX_WIDTH_DEF;
    // a result holds the core for a walk over all (2R+1)^2 taps; leave margin after that
    localparam int SETTLE    = TAPS * TAPS + 40;
    localparam longint LIMIT = 12_000_000;
    localparam int RAND_ITEMS = 650;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } blur_px_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_index;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [7:0]          s_in_red;
    logic [7:0]          s_in_green;
    logic [7:0]          s_in_blue;
    logic [7:0]          s_in_alpha;
    logic                m_valid;
    logic                m_ready;
    logic [7:0]          m_out_red;
    logic [7:0]          m_out_green;
    logic [7:0]          m_out_blue;
    logic [7:0]          m_out_alpha;
    logic                m_frame_last;

    gaussian_blur_rgba_clamp_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_in_red     (s_in_red),
        .s_in_green   (s_in_green),
        .s_in_blue    (s_in_blue),
        .s_in_alpha   (s_in_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_frame_last (m_frame_last)
    );

    // blur predictor state
    int unsigned   tap_weight [TAPS][TAPS];
    logic [31:0]   line_mem [DEPTH];
    int unsigned   cfg_width;
    int unsigned   cfg_height;
    int unsigned   lat_w;
    int unsigned   lat_h;
    int unsigned   in_col;
    int unsigned   in_row;
    int unsigned   out_col;
    int unsigned   out_row;
    bit            frame_busy;
    bit            pixels_done;

    blur_px_t      blurred_q [$];
    int            errors;
    longint        cycles = 0;
    bit            quiet;
    int            n_frames;
    int            n_pixels;
    int            n_drains;
    int            n_ignored;
    int            n_results;

    // weights: per-axis exp(-2 i^2 / R^2) via truncated q30 series, then q0.frac
    function automatic void make_weights();
        longint unsigned g [RAD+1];
        longint unsigned h [RAD+1];
        longint unsigned total;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned p;
        int n;
        total = 0;
        for (int i = 0; i <= RAD; i++) begin
            term = 64'd1 << 30;
            acc  = term;
            n    = 1;
            while (n < 64 && term != 0) begin
                term = (term * longint'(2 * i * i)) / (longint'(RAD * RAD) * longint'(n));
                acc  = acc + term;
                n++;
            end
            g[i]  = (64'd1 << 60) / acc;
            total = total + ((i == 0) ? g[i] : 2 * g[i]);
        end
        for (int i = 0; i <= RAD; i++) h[i] = (g[i] << 30) / total;
        for (int a = 0; a < TAPS; a++) begin
            for (int b = 0; b < TAPS; b++) begin
                p = h[(a < RAD) ? RAD - a : a - RAD] * h[(b < RAD) ? RAD - b : b - RAD];
                p = (p + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
                tap_weight[a][b] = int'(p);
            end
        end
    endfunction

    function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    // weighted neighborhood sum with edge clamping, then truncate and saturate
    function automatic blur_px_t blur_window(int oy, int ox);
        longint unsigned acc [4];
        longint unsigned v;
        blur_px_t px;
        logic [31:0] word;
        int ny;
        int nx;
        logic [7:0] ch [4];
        for (int c = 0; c < 4; c++) acc[c] = 0;
        for (int ky = -RAD; ky <= RAD; ky++) begin
            ny = oy + ky;
            if (ny < 0) ny = 0;
            if (ny > int'(lat_h) - 1) ny = int'(lat_h) - 1;
            for (int kx = -RAD; kx <= RAD; kx++) begin
                nx = ox + kx;
                if (nx < 0) nx = 0;
                if (nx > int'(lat_w) - 1) nx = int'(lat_w) - 1;
                word = line_mem[(ny * int'(lat_w) + nx) % DEPTH];
                for (int c = 0; c < 4; c++)
                    acc[c] += longint'(tap_weight[ky+RAD][kx+RAD]) * word[8*c +: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            v = acc[c] >> FRAC;
            ch[c] = (v > 255) ? 8'hff : v[7:0];
        end
        px.red   = ch[0];
        px.green = ch[1];
        px.blue  = ch[2];
        px.alpha = ch[3];
        px.last  = 1'b0;
        return px;
    endfunction

    function automatic blur_px_t next_output();
        blur_px_t px;
        bit fin;
        fin     = (out_row == lat_h - 1) && (out_col == lat_w - 1);
        px      = blur_window(out_row, out_col);
        px.last = fin;
        out_col++;
        if (out_col >= lat_w) begin
            out_col = 0;
            out_row++;
        end
        if (fin) begin
            frame_busy  = 0;
            pixels_done = 0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        return px;
    endfunction

    // one accepted transfer; returns 1 when it yields a blurred pixel
    function automatic bit blur_accept(logic kind, logic [31:0] word, output blur_px_t px);
        int unsigned idx;
        px = '{default: '0};
        if (kind == KIND_DRAIN) begin
            if (!pixels_done) return 0;
            px = next_output();
            return 1;
        end
        if (pixels_done) return 0;
        if (!frame_busy) begin
            lat_w      = clamp_size(cfg_width, MAX_WIDTH_DEF);
            lat_h      = clamp_size(cfg_height, MAX_HEIGHT_DEF);
            frame_busy = 1;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        idx = in_row * lat_w + in_col;
        line_mem[idx % DEPTH] = word;
        in_col++;
        if (in_col >= lat_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= lat_h) begin
                in_row      = 0;
                pixels_done = 1;
            end
        end
        if (idx >= RAD * lat_w + RAD) begin
            px = next_output();
            return 1;
        end
        return 0;
    endfunction

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    // send one transfer; a typed expectation, where given, replaces the prediction
    task automatic send_item(input logic kind, input logic [31:0] word,
                             input bit use_typed, input blur_px_t typed);
        int gap;
        blur_px_t px;
        bit got;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_in_red   <= word[7:0];
        s_in_green <= word[15:8];
        s_in_blue  <= word[23:16];
        s_in_alpha <= word[31:24];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = blur_accept(kind, word, px);
        if (got) blurred_q.push_back(use_typed ? typed : px);
        else n_ignored++;
        if (kind == KIND_DRAIN) n_drains++;
        else n_pixels++;
    endtask

    // wait for every expected result, then for the core to finish its last window
    task automatic settle();
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_IMAGE_WIDTH;
        cfg_wr_data  <= w[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_index <= REG_IMAGE_HEIGHT;
        cfg_wr_data  <= h[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        cfg_width  = w & 32'h7ff;
        cfg_height = h & 32'h7ff;
    endtask

    function automatic logic [31:0] pick_pixel(int mode);
        case (mode)
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                       {8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}}};
            default: return $urandom;
        endcase
    endfunction

    // one frame: well-formed pixel run with some stray drains and pixels mixed in
    task automatic run_frame(input int unsigned w, input int unsigned h);
        int unsigned npx;
        int mode;
        blur_px_t none;
        none = '{default: '0};
        settle();
        set_frame_size(w, h);
        quiet = ($urandom_range(0, 4) == 0);
        mode  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
        npx   = clamp_size(w & 32'h7ff, MAX_WIDTH_DEF) * clamp_size(h & 32'h7ff, MAX_HEIGHT_DEF);
        for (int unsigned i = 0; i < npx; i++) begin
            // drain ahead of complete input is dropped by the core
            if ($urandom_range(0, 15) == 0) send_item(KIND_DRAIN, $urandom, 0, none);
            send_item(KIND_PIXEL, pick_pixel(mode), 0, none);
        end
        // pixel while the frame is still flushing is dropped too
        if ($urandom_range(0, 3) == 0) send_item(KIND_PIXEL, $urandom, 0, none);
        while (frame_busy) send_item(KIND_DRAIN, $urandom, 0, none);
        s_valid <= 1'b0;
        n_frames++;
    endtask

    // directed rows on a 1x1 frame: kind, pixel, typed flag, typed result
    typedef struct {
        logic        kind;
        logic [31:0] word;
        bit          typed;
        blur_px_t    want;
    } stim_row_t;

    stim_row_t directed [10] = '{
        '{KIND_DRAIN, 32'h1234_5678, 0, '{default: '0}},           // drain before input, dropped
        '{KIND_PIXEL, 32'h0000_0000, 0, '{default: '0}},
        '{KIND_PIXEL, 32'hffff_ffff, 0, '{default: '0}},           // pixel while flushing, dropped
        '{KIND_DRAIN, 32'hffff_ffff, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{KIND_PIXEL, 32'hffff_ffff, 0, '{default: '0}},
        '{KIND_DRAIN, 32'h0000_0000, 0, '{default: '0}},
        '{KIND_PIXEL, 32'h55aa_55aa, 0, '{default: '0}},
        '{KIND_DRAIN, 32'h0000_0000, 0, '{default: '0}},
        '{KIND_PIXEL, 32'haa55_aa55, 0, '{default: '0}},
        '{KIND_DRAIN, 32'h0000_0000, 0, '{default: '0}}
    };

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_gaussian_blur_rgba_clamp_core failed");
            $finish;
        end
    end

    // result side: random stall per transfer, compare with the oldest prediction
    initial begin
        blur_px_t want;
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            n_results++;
            if (blurred_q.size() == 0) begin
                report("blurred pixel with nothing expected");
            end else begin
                want = blurred_q.pop_front();
                if (m_out_red !== want.red)
                    report($sformatf("red %0h want %0h", m_out_red, want.red));
                if (m_out_green !== want.green)
                    report($sformatf("green %0h want %0h", m_out_green, want.green));
                if (m_out_blue !== want.blue)
                    report($sformatf("blue %0h want %0h", m_out_blue, want.blue));
                if (m_out_alpha !== want.alpha)
                    report($sformatf("alpha %0h want %0h", m_out_alpha, want.alpha));
                if (m_frame_last !== want.last)
                    report($sformatf("frame_last %0b want %0b", m_frame_last, want.last));
            end
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        int start_px;
        errors = 0; quiet = 0;
        n_frames = 0; n_pixels = 0; n_drains = 0; n_ignored = 0; n_results = 0;
        cfg_width = 1024; cfg_height = 1024;
        lat_w = 1; lat_h = 1;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        frame_busy = 0; pixels_done = 0;
        make_weights();
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= REG_IMAGE_WIDTH;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_kind       <= KIND_PIXEL;
        s_in_red     <= '0;
        s_in_green   <= '0;
        s_in_blue    <= '0;
        s_in_alpha   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows on a single-pixel frame
        set_frame_size(1, 1);
        foreach (directed[i])
            send_item(directed[i].kind, directed[i].word, directed[i].typed, directed[i].want);
        s_valid <= 1'b0;

        // size extremes: zero reads as one, oversize height reads as the maximum
        run_frame(0, 0);
        run_frame(1, 2047);
        run_frame(2, 17);

        // random frames, mostly small
        start_px = n_pixels + n_drains;
        while (n_pixels + n_drains - start_px < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(17, 60), $urandom_range(1, 4));
            else
                run_frame($urandom_range(1, 20), $urandom_range(1, 10));
        end

        settle();
        $display("covered %0d frames: %0d pixels, %0d drains, %0d dropped transfers",
                 n_frames, n_pixels, n_drains, n_ignored);
        $display("checked %0d blurred pixels in %0d cycles", n_results, cycles);
        if (errors == 0) begin
            $display("tb_gaussian_blur_rgba_clamp_core passed");
        end else begin
            $display("tb_gaussian_blur_rgba_clamp_core failed");
        end
        $finish;
    end

endmodule
